// File: rtl/tfb_pkg.sv
package tfb_pkg;

  // Largest payload a frame may carry before it is rejected.
  localparam int unsigned TFB_MAX_PAYLOAD = 1024;

  // Depth of the queue between the front and back parts.
  localparam int unsigned TFB_QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VERSION_NUMBER    = 2'd0;
  localparam logic [1:0] CFG_CRAFT_IDENTIFIER  = 2'd1;
  localparam logic [1:0] CFG_SEGMENT_HEADER_ON = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        final_byte;
    logic [10:0] payload_count;
    logic [5:0]  channel_id;
    logic        bypass_bit;
    logic        control_bit;
    logic [1:0]  seq_flags;
    logic [5:0]  map_id;
  } tfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       length_error;
  } tfb_out_t;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic        is_error;
    logic        is_first;
    logic        is_last;
    logic        seg_on;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [7:0]  hdr2;
    logic [15:0] frame_len;
    logic [7:0]  seg_byte;
    logic [7:0]  data_byte;
  } tfb_job_t;

endpackage

// File: rtl/tfb_front.sv
module tfb_front #(
  parameter int unsigned MAX_PAYLOAD = tfb_pkg::TFB_MAX_PAYLOAD
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tfb_pkg::tfb_in_t                   in_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               q_full,
  output logic                               q_push,
  output tfb_pkg::tfb_job_t                  q_job
);
  import tfb_pkg::*;

  logic [1:0]  version_r;
  logic [9:0]  craft_r;
  logic        seg_on_r;
  logic        in_frame_r;
  logic        in_frame_nxt;
  logic        dropping_r;
  logic        dropping_nxt;
  logic        accept;
  logic        too_long;
  logic        want_push;
  logic [15:0] frame_len;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  // Counts up to 2^11-1, limit up to 2^16: compare in 17 bits.
  assign too_long  = {6'd0, in_data.payload_count} > 17'(MAX_PAYLOAD);
  assign frame_len = {5'd0, in_data.payload_count} - 16'd1;

  always_comb begin
    in_frame_nxt = in_frame_r;
    dropping_nxt = dropping_r;
    want_push    = 1'b0;
    if (in_data.first_byte) begin
      want_push = 1'b1;
      if (too_long) begin
        in_frame_nxt = 1'b0;
        dropping_nxt = !in_data.final_byte;
      end else begin
        in_frame_nxt = !in_data.final_byte;
        dropping_nxt = 1'b0;
      end
    end else if (dropping_r) begin
      if (in_data.final_byte) begin
        dropping_nxt = 1'b0;
      end
    end else if (in_frame_r) begin
      want_push = 1'b1;
      if (in_data.final_byte) begin
        in_frame_nxt = 1'b0;
      end
    end
  end

  assign q_push = accept && want_push;

  always_comb begin
    q_job.is_error  = in_data.first_byte && too_long;
    q_job.is_first  = in_data.first_byte;
    q_job.is_last   = in_data.final_byte;
    q_job.seg_on    = seg_on_r && !in_data.control_bit;
    q_job.hdr0      = {version_r, in_data.bypass_bit, in_data.control_bit, 2'b00,
                       craft_r[9:8]};
    q_job.hdr1      = craft_r[7:0];
    q_job.hdr2      = {in_data.channel_id, 2'b00};
    q_job.frame_len = frame_len;
    q_job.seg_byte  = {in_data.seq_flags, in_data.map_id};
    q_job.data_byte = in_data.payload_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r  <= '0;
      craft_r    <= '0;
      seg_on_r   <= 1'b0;
      in_frame_r <= 1'b0;
      dropping_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERSION_NUMBER:    version_r <= cfg_data[1:0];
          CFG_CRAFT_IDENTIFIER:  craft_r   <= cfg_data[9:0];
          CFG_SEGMENT_HEADER_ON: seg_on_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        in_frame_r <= in_frame_nxt;
        dropping_r <= dropping_nxt;
      end
    end
  end

endmodule

// File: rtl/tfb_queue.sv
module tfb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tfb_pkg::tfb_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tfb_pkg::tfb_job_t head_job
);
  import tfb_pkg::*;

  localparam int unsigned PTR_W = $clog2(TFB_QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TFB_QUEUE_DEPTH + 1);

  tfb_job_t         slot_r [TFB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full       = count_r == CNT_W'(TFB_QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(TFB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(TFB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/tfb_back.sv
module tfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  tfb_pkg::tfb_job_t head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tfb_pkg::tfb_out_t out_data
);
  import tfb_pkg::*;

  localparam logic [3:0] ST_HDR0  = 4'd0;
  localparam logic [3:0] ST_HDR1  = 4'd1;
  localparam logic [3:0] ST_HDR2  = 4'd2;
  localparam logic [3:0] ST_LENH  = 4'd3;
  localparam logic [3:0] ST_LENL  = 4'd4;
  localparam logic [3:0] ST_SEG   = 4'd5;
  localparam logic [3:0] ST_DATA  = 4'd6;
  localparam logic [3:0] ST_CRCH  = 4'd7;
  localparam logic [3:0] ST_CRCL  = 4'd8;
  localparam logic [3:0] ST_ERR   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // CRC-16-CCITT, polynomial 0x1021, one byte MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic        busy_r;
  logic [3:0]  step_r;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic        out_valid_r;
  tfb_out_t    out_r;
  tfb_out_t    out_nxt;
  logic [3:0]  cur_step;
  logic [3:0]  next_step;
  logic        fire;
  logic        feed_crc;

  assign fire = head_valid && (!out_valid_r || !out_stall);
  assign pop  = fire && (next_step == ST_DONE);

  always_comb begin
    if (busy_r) begin
      cur_step = step_r;
    end else if (head_job.is_error) begin
      cur_step = ST_ERR;
    end else if (head_job.is_first) begin
      cur_step = ST_HDR0;
    end else begin
      cur_step = ST_DATA;
    end
  end

  always_comb begin
    case (cur_step)
      ST_HDR0: next_step = ST_HDR1;
      ST_HDR1: next_step = ST_HDR2;
      ST_HDR2: next_step = ST_LENH;
      ST_LENH: next_step = ST_LENL;
      ST_LENL: next_step = head_job.seg_on ? ST_SEG : ST_DATA;
      ST_SEG:  next_step = ST_DATA;
      ST_DATA: next_step = head_job.is_last ? ST_CRCH : ST_DONE;
      ST_CRCH: next_step = ST_CRCL;
      default: next_step = ST_DONE;
    endcase
  end

  always_comb begin
    out_nxt  = '0;
    feed_crc = 1'b1;
    case (cur_step)
      ST_HDR0: out_nxt.out_byte = head_job.hdr0;
      ST_HDR1: out_nxt.out_byte = head_job.hdr1;
      ST_HDR2: out_nxt.out_byte = head_job.hdr2;
      ST_LENH: out_nxt.out_byte = head_job.frame_len[15:8];
      ST_LENL: out_nxt.out_byte = head_job.frame_len[7:0];
      ST_SEG:  out_nxt.out_byte = head_job.seg_byte;
      ST_DATA: out_nxt.out_byte = head_job.data_byte;
      ST_CRCH: begin
        out_nxt.out_byte = crc_r[15:8];
        feed_crc         = 1'b0;
      end
      ST_CRCL: begin
        out_nxt.out_byte  = crc_r[7:0];
        out_nxt.frame_end = 1'b1;
        feed_crc          = 1'b0;
      end
      default: begin
        out_nxt.frame_end    = 1'b1;
        out_nxt.length_error = 1'b1;
        feed_crc             = 1'b0;
      end
    endcase
  end

  // The first header byte always starts from the preset value.
  always_comb begin
    if (cur_step == ST_HDR0) begin
      crc_nxt = crc_byte(16'hFFFF, out_nxt.out_byte);
    end else if (feed_crc) begin
      crc_nxt = crc_byte(crc_r, out_nxt.out_byte);
    end else if (cur_step == ST_CRCL) begin
      crc_nxt = 16'hFFFF;
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_HDR0;
      crc_r       <= 16'hFFFF;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
        if (next_step == ST_DONE) begin
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          step_r <= next_step;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/tc_transfer_frame_builder_top.sv
// Telecommand transfer frame builder: one payload byte in, frame bytes out.
// An item's result passes through the job queue and then the output register.
// Throughput: payload bytes pass at one per cycle while out_stall is low; a first byte
// expands into header, optional segment byte and data; a final byte adds the CRC.
// The back sequencer's one byte per unstalled cycle sets the rate; the queue absorbs bursts.
// Reset (rst_n, synchronous, active low) empties the queue, clears frame state and
// configuration registers to zero and presets the CRC to all ones.
module tc_transfer_frame_builder_top #(
  parameter int unsigned MAX_PAYLOAD = tfb_pkg::TFB_MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tfb_pkg::tfb_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tfb_pkg::tfb_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tfb_pkg::*;

  // The front part tracks frame and drop state and turns every item that
  // produces output into one job; the back part expands each job into its
  // bytes, keeps the running CRC and holds the result in an output register.
  logic     q_full;
  logic     q_push;
  tfb_job_t q_push_job;
  logic     q_pop;
  logic     q_head_valid;
  tfb_job_t q_head_job;

  tfb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_push_job)
  );

  // Short job queue so the input side keeps taking payload bytes while the
  // back part is still emitting a header or a trailer.
  tfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  tfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: sim/tfb_frame_checker.sv
`timescale 1ns / 100ps

module tfb_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = tfb_pkg::TFB_MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  tfb_pkg::tfb_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  tfb_pkg::tfb_out_t               out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              pending_bytes,
  output int                              fail_count
);

  import tfb_pkg::*;

  // Local copy of the register file and of the frame state.
  logic [1:0]  version_q;
  logic [9:0]  craft_id_q;
  logic        segment_on_q;
  logic [15:0] frame_crc;
  logic        frame_open;
  logic        frame_dropping;

  tfb_out_t expected_frame_bytes[$];

  function automatic logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] value);
    logic [15:0] acc;
    acc = crc ^ {value, 8'h00};
    for (int i = 0; i < 8; i++) begin
      acc = acc[15] ? ((acc << 1) ^ 16'h1021) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic void push_result(logic [7:0] value, logic last, logic err);
    tfb_out_t res;
    res.out_byte     = value;
    res.frame_end    = last;
    res.length_error = err;
    expected_frame_bytes.push_back(res);
  endfunction

  // Bytes that belong to the frame body are covered by the CRC.
  function automatic void push_frame_byte(logic [7:0] value);
    frame_crc = crc_ccitt_byte(frame_crc, value);
    push_result(value, 1'b0, 1'b0);
  endfunction

  function automatic void encode_item(tfb_in_t item);
    logic [15:0] length_field;
    if (item.first_byte) begin
      if (item.payload_count > MAX_PAYLOAD) begin
        frame_open     = 1'b0;
        frame_dropping = !item.final_byte;
        push_result(8'h00, 1'b1, 1'b1);
        return;
      end
      frame_dropping = 1'b0;
      frame_open     = 1'b1;
      frame_crc      = 16'hFFFF;
      length_field   = {5'b0, item.payload_count} - 16'd1;
      push_frame_byte({version_q, item.bypass_bit, item.control_bit, 2'b00, craft_id_q[9:8]});
      push_frame_byte(craft_id_q[7:0]);
      push_frame_byte({item.channel_id, 2'b00});
      push_frame_byte(length_field[15:8]);
      push_frame_byte(length_field[7:0]);
      if (segment_on_q && !item.control_bit) begin
        push_frame_byte({item.seq_flags, item.map_id});
      end
    end else if (frame_dropping) begin
      if (item.final_byte) begin
        frame_dropping = 1'b0;
      end
      return;
    end else if (!frame_open) begin
      return;
    end
    push_frame_byte(item.payload_byte);
    if (item.final_byte) begin
      push_result(frame_crc[15:8], 1'b0, 1'b0);
      push_result(frame_crc[7:0], 1'b1, 1'b0);
      frame_open = 1'b0;
      frame_crc  = 16'hFFFF;
    end
  endfunction

  always @(posedge clk) begin
    tfb_out_t want;
    int       errors;
    errors = 0;
    if (!rst_n) begin
      version_q      = '0;
      craft_id_q     = '0;
      segment_on_q   = 1'b0;
      frame_crc      = 16'hFFFF;
      frame_open     = 1'b0;
      frame_dropping = 1'b0;
      expected_frame_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERSION_NUMBER:    version_q    = cfg_data[1:0];
          CFG_CRAFT_IDENTIFIER:  craft_id_q   = cfg_data[9:0];
          CFG_SEGMENT_HEADER_ON: segment_on_q = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        encode_item(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_frame_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h frame_end %0b length_error %0b",
                 out_data.out_byte, out_data.frame_end, out_data.length_error);
          errors++;
        end else begin
          want = expected_frame_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_data.frame_end);
            errors++;
          end
          if (out_data.length_error !== want.length_error) begin
            $error("length_error: expected %0b, actual %0b",
                   want.length_error, out_data.length_error);
            errors++;
          end
        end
      end
    end
    pending_bytes <= expected_frame_bytes.size();
    fail_count    <= fail_count + errors;
  end

endmodule

// File: sim/tb_tc_transfer_frame_builder_top.sv
`timescale 1ns / 100ps

module tb_tc_transfer_frame_builder_top;

  import tfb_pkg::*;

  // Cycles to let pass once nothing is expected any more: items that make no
  // result may still be in flight.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT    = 2000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  tfb_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  tfb_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int pending_bytes;
  int fail_count;

  // Gap and stall control. Input gaps are switched per frame so that some
  // stretches run back to back; both are turned off for the last phase.
  bit gaps_enable;
  bit gaps_now;
  bit stall_enable;
  int phase_items;
  int idle_cycles;

  tc_transfer_frame_builder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees the same pins as the block and keeps its own frame model.
  tfb_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_bytes (pending_bytes),
    .fail_count    (fail_count)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The receiver holds off the block in random bursts while stalls are enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_enable && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Writes one register and leaves cfg_valid high, so that back-to-back
  // writes never lower and raise it within the same step.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input logic [1:0] version, input logic [9:0] craft_id,
                             input logic segment_on);
    write_register(CFG_VERSION_NUMBER, {8'b0, version});
    write_register(CFG_CRAFT_IDENTIFIER, craft_id);
    write_register(CFG_SEGMENT_HEADER_ON, {9'b0, segment_on});
    cfg_valid <= 1'b0;
  endtask

  // Presents one item, with a random gap ahead of it when gaps are on, and
  // holds it steady until the block takes it.
  task automatic send_item(input tfb_in_t item);
    if (gaps_now && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets the block run dry before the registers are touched again. The first
  // edge makes sure the count of expected results includes the last item.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tfb_in_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(tfb_in_t)-1:0];
  endfunction

  function automatic tfb_in_t make_item(logic [7:0] value, logic first, logic last,
                                        logic [10:0] count, logic [5:0] chan,
                                        logic bypass, logic ctrl, logic [1:0] seqf,
                                        logic [5:0] map);
    tfb_in_t item;
    item.payload_byte   = value;
    item.first_byte     = first;
    item.final_byte     = last;
    item.payload_count  = count;
    item.channel_id     = chan;
    item.bypass_bit     = bypass;
    item.control_bit    = ctrl;
    item.seq_flags      = seqf;
    item.map_id         = map;
    return item;
  endfunction

  // Sends a frame of nbytes payload bytes with random content. The header
  // fields ride on the first byte; the other bytes carry random junk in those
  // fields, which the block must ignore. Without close the frame gets no
  // final byte and is left for the next first byte to abandon.
  task automatic send_frame(input int nbytes, input logic [10:0] count, input bit close);
    tfb_in_t item;
    for (int i = 0; i < nbytes; i++) begin
      item = random_item();
      item.first_byte = (i == 0);
      item.final_byte = close && (i == nbytes - 1);
      if (i == 0) begin
        item.payload_count = count;
      end
      send_item(item);
      phase_items++;
    end
  endtask

  initial begin
    int          nbytes;
    int          pick;
    logic [10:0] count;
    tfb_in_t     stray;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    gaps_enable  = 1'b1;
    gaps_now     = 1'b1;
    stall_enable = 1'b1;
    phase_items  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With the reset configuration: a one-byte frame whose
    // first byte is also its final byte, count one and all other fields at zero.
    send_item(make_item(8'h00, 1'b1, 1'b1, 11'd1, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));
    drain_block();

    // Top values in every register, segment header on.
    load_config(2'd3, 10'd1023, 1'b1);

    // Zero count gives a length field of all ones; every header field but the
    // control bit at its top value, so the segment byte is all ones too.
    send_item(make_item(8'hFF, 1'b1, 1'b0, 11'd0, 6'd63, 1'b1, 1'b0, 2'd3, 6'd63));
    send_item(make_item(8'h5A, 1'b0, 1'b0, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));
    send_item(make_item(8'hA5, 1'b0, 1'b1, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));

    // Control frame at the largest legal count: no segment byte.
    send_item(make_item(8'h81, 1'b1, 1'b0, 11'd1024, 6'd21, 1'b0, 1'b1, 2'd2, 6'd42));
    send_item(make_item(8'h7E, 1'b0, 1'b1, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));

    // One over the limit: a single error result, and the rest of the frame
    // up to its final byte is dropped.
    send_item(make_item(8'h11, 1'b1, 1'b0, 11'd1025, 6'd5, 1'b1, 1'b0, 2'd1, 6'd3));
    send_item(make_item(8'h22, 1'b0, 1'b0, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));
    send_item(make_item(8'h33, 1'b0, 1'b1, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));

    // Largest count in the field, first and final on the same byte: the error
    // result and nothing left to drop.
    send_item(make_item(8'hEE, 1'b1, 1'b1, 11'd2047, 6'd63, 1'b1, 1'b1, 2'd3, 6'd63));

    // A byte with no frame open is ignored.
    send_item(make_item(8'h44, 1'b0, 1'b1, 11'd7, 6'd9, 1'b1, 1'b1, 2'd1, 6'd9));

    // A frame abandoned by a new first byte, which starts a frame of its own.
    send_item(make_item(8'h01, 1'b1, 1'b0, 11'd3, 6'd1, 1'b0, 1'b0, 2'd1, 6'd1));
    send_item(make_item(8'h02, 1'b0, 1'b0, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));
    send_item(make_item(8'h03, 1'b1, 1'b1, 11'd2, 6'd2, 1'b1, 1'b0, 2'd2, 6'd2));

    // The count disagrees with the bytes sent; the header still carries it.
    send_item(make_item(8'hC3, 1'b1, 1'b0, 11'd5, 6'd33, 1'b0, 1'b0, 2'd0, 6'd17));
    send_item(make_item(8'h3C, 1'b0, 1'b1, 11'd0, 6'd0, 1'b0, 1'b0, 2'd0, 6'd0));
    drain_block();

    // Random part: six phases, each with its own register setting. The first
    // uses all zeros; the last runs without gaps or stalls.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        load_config(2'd0, 10'd0, 1'b0);
      end else begin
        load_config(2'($urandom), 10'($urandom), 1'($urandom));
      end
      gaps_enable  = (phase < 5);
      stall_enable = (phase < 5);
      phase_items  = 0;
      while (phase_items < 24) begin
        gaps_now = gaps_enable && ($urandom_range(0, 2) != 0);
        pick     = $urandom_range(0, 9);
        nbytes   = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        if (pick == 0) begin
          // Noise: a stray byte, taken into an open frame, dropped or ignored depending on the state.
          stray = random_item();
          stray.first_byte = 1'b0;
          send_item(stray);
          phase_items++;
        end else if (pick == 1) begin
          send_frame(nbytes, 11'(nbytes), 1'b0);
        end else if (pick == 2) begin
          send_frame(nbytes, 11'($urandom_range(1025, 2047)), 1'b1);
        end else begin
          // Mostly a matching count, sometimes any legal one.
          if ($urandom_range(0, 9) < 6) begin
            count = 11'(nbytes);
          end else begin
            count = 11'($urandom_range(0, 1024));
          end
          send_frame(nbytes, count, 1'b1);
        end
      end
      drain_block();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tfb_pkg.sv
rtl/tfb_front.sv
rtl/tfb_queue.sv
rtl/tfb_back.sv
rtl/tc_transfer_frame_builder_top.sv
sim/tfb_frame_checker.sv
sim/tb_tc_transfer_frame_builder_top.sv
